### src/ssm_pkg.sv
// shared types, constants and glyph tables for the seven-segment serializer
package ssm_pkg;

    localparam int NumDigits    = 4;
    localparam int BitsPerDigit = 8;
    localparam int ScanWidth    = $clog2(NumDigits);
    localparam int CountWidth   = $clog2(BitsPerDigit);

    // reciprocal constants: x / d == (x * Recip) >> Shift for every 16-bit x
    localparam logic [16:0] Recip10    = 17'd52429;
    localparam int          Shift10    = 19;
    localparam logic [16:0] Recip100   = 17'd83887;
    localparam int          Shift100   = 23;
    localparam logic [16:0] Recip1000  = 17'd67109;
    localparam int          Shift1000  = 26;

    localparam logic [7:0] DpBit = 8'h80;

    localparam logic [1:0] MODE_DP_TENS     = 2'd0;
    localparam logic [1:0] MODE_NO_DP       = 2'd1;
    localparam logic [1:0] MODE_DP_HUNDREDS = 2'd2;
    localparam logic [1:0] MODE_BLANK       = 2'd3;

    typedef logic [7:0] t_pattern;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_TICK = 1'b1
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [15:0] number_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0] digit_enable_n;
        logic       serial_bit;
        logic       latch;
    } t_out_item;

    typedef struct packed {
        t_action     action;
        logic [15:0] number_value;
        logic [12:0] q10;
        logic [9:0]  q100;
        logic [6:0]  q1000;
    } t_quot;

    typedef struct packed {
        logic [3:0] digit_enable_n;
        t_pattern   pattern;
    } t_scan_item;

    function automatic t_pattern digit_glyph(input logic [3:0] digit);
        t_pattern g;
        case (digit)
            4'd0:    g = 8'h3F;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5B;
            4'd3:    g = 8'h4F;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6D;
            4'd6:    g = 8'h7D;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7F;
            4'd9:    g = 8'h6F;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    function automatic t_pattern unit_glyph(input logic [1:0] mode);
        t_pattern g;
        unique case (mode)
            MODE_DP_TENS:     g = 8'h3E;
            MODE_NO_DP:       g = 8'h77;
            MODE_DP_HUNDREDS: g = 8'h73;
            MODE_BLANK:       g = 8'h00;
            default:          g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

### src/seven_segment_mux_serializer.sv
// top level of the multiplexed seven-segment display serializer
//
// A load item (action 0) takes the lowest three decimal digits of the number and stores
// their segment patterns plus a unit symbol picked by the configured mode, which may also
// set a decimal point; a tick item (action 1) sends the current scan digit's 8 pattern
// bits msb first, one output item per cycle unless the output stalls, with its active-low
// enable and a latch flag on the eighth bit, and steps the scan position as it is taken.
// Items pass an input register and a quotient register (reciprocal multiplies) before a
// tick's pattern is loaded into the output shifter. Loads are taken one per cycle unless
// a tick ahead waits for the shifter; a tick holds the shifter until its eighth bit is
// taken, and the next tick may load as that bit leaves. Items are handled in order.
module seven_segment_mux_serializer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ssm_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ssm_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_data
);

    logic                r_in_valid;
    ssm_pkg::t_in_item   r_in_item;
    logic [1:0]          r_mode;
    logic                div_valid;
    ssm_pkg::t_quot      div_quot;
    logic                div_leave;
    logic                div_free;
    logic                in_free;
    logic                ser_ready;
    logic                store_write;
    logic                tick_go;
    ssm_pkg::t_scan_item scan_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ssm_pkg::MODE_DP_TENS;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    assign store_write = div_valid && (div_quot.action == ssm_pkg::ACT_LOAD);
    assign tick_go     = div_valid && (div_quot.action == ssm_pkg::ACT_TICK) && ser_ready;
    assign div_leave   = store_write || tick_go;
    assign div_free    = !div_valid || div_leave;
    assign in_free     = !r_in_valid || div_free;
    assign o_in_stall  = !in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free) begin
            r_in_item <= i_in_item;
        end
    end

    ssm_divide u_divide (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (div_free),
        .i_valid   (r_in_valid),
        .i_item    (r_in_item),
        .o_valid   (div_valid),
        .o_quot    (div_quot)
    );

    ssm_glyph_store u_glyph_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_quot  (div_quot),
        .i_write (store_write),
        .i_tick  (tick_go),
        .o_scan  (scan_item)
    );

    ssm_serializer u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (tick_go),
        .i_scan  (scan_item),
        .i_stall (i_out_stall),
        .o_ready (ser_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

endmodule

### src/ssm_divide.sv
// quotient stage: number divided by 10, 100 and 1000 via reciprocal multiplies
module ssm_divide (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic             i_valid,
    input  ssm_pkg::t_in_item i_item,
    output logic             o_valid,
    output ssm_pkg::t_quot   o_quot
);

    logic [32:0]    prod10;
    logic [32:0]    prod100;
    logic [32:0]    prod1000;
    ssm_pkg::t_quot n_quot;
    ssm_pkg::t_quot r_quot;
    logic           r_valid;

    assign prod10   = 33'(i_item.number_value) * 33'(ssm_pkg::Recip10);
    assign prod100  = 33'(i_item.number_value) * 33'(ssm_pkg::Recip100);
    assign prod1000 = 33'(i_item.number_value) * 33'(ssm_pkg::Recip1000);

    always_comb begin
        n_quot.action       = i_item.action;
        n_quot.number_value = i_item.number_value;
        n_quot.q10          = prod10[ssm_pkg::Shift10 +: 13];
        n_quot.q100         = prod100[ssm_pkg::Shift100 +: 10];
        n_quot.q1000        = prod1000[ssm_pkg::Shift1000 +: 7];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_quot <= n_quot;
        end
    end

    assign o_valid = r_valid;
    assign o_quot  = r_quot;

endmodule

### src/ssm_glyph_store.sv
// digit extraction, glyph lookup, pattern store and scan position
module ssm_glyph_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_mode,
    input  ssm_pkg::t_quot       i_quot,
    input  logic                 i_write,
    input  logic                 i_tick,
    output ssm_pkg::t_scan_item  o_scan
);

    logic [15:0]       ten_q10;
    logic [12:0]       ten_q100;
    logic [9:0]        ten_q1000;
    logic [3:0]        ones;
    logic [3:0]        tens;
    logic [3:0]        hundreds;
    ssm_pkg::t_pattern n_pat [ssm_pkg::NumDigits];
    ssm_pkg::t_pattern r_pat [ssm_pkg::NumDigits];
    logic [ssm_pkg::ScanWidth-1:0] r_scan;

    assign ten_q10   = 16'({i_quot.q10, 3'b000}) + 16'({i_quot.q10, 1'b0});
    assign ten_q100  = 13'({i_quot.q100, 3'b000}) + 13'({i_quot.q100, 1'b0});
    assign ten_q1000 = 10'({i_quot.q1000, 3'b000}) + 10'({i_quot.q1000, 1'b0});

    assign ones     = 4'(i_quot.number_value - ten_q10);
    assign tens     = 4'(i_quot.q10 - ten_q100);
    assign hundreds = 4'(i_quot.q100 - ten_q1000);

    always_comb begin
        n_pat[0] = ssm_pkg::unit_glyph(i_mode);
        n_pat[1] = ssm_pkg::digit_glyph(ones);
        n_pat[2] = ssm_pkg::digit_glyph(tens);
        n_pat[3] = ssm_pkg::digit_glyph(hundreds);
        if (i_mode == ssm_pkg::MODE_DP_TENS) begin
            n_pat[2] = n_pat[2] | ssm_pkg::DpBit;
        end else if (i_mode == ssm_pkg::MODE_DP_HUNDREDS) begin
            n_pat[3] = n_pat[3] | ssm_pkg::DpBit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ssm_pkg::NumDigits; i++) begin
                r_pat[i] <= '0;
            end
            r_scan <= '0;
        end else begin
            if (i_write) begin
                for (int i = 0; i < ssm_pkg::NumDigits; i++) begin
                    r_pat[i] <= n_pat[i];
                end
            end
            if (i_tick) begin
                r_scan <= r_scan + 1'b1;
            end
        end
    end

    // position 0 drives the top enable bit
    assign o_scan.pattern        = r_pat[r_scan];
    assign o_scan.digit_enable_n = ~(4'b1000 >> r_scan);

endmodule

### src/ssm_serializer.sv
// output register shifting one digit pattern out msb first
module ssm_serializer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  ssm_pkg::t_scan_item i_scan,
    input  logic                i_stall,
    output logic                o_ready,
    output logic                o_valid,
    output ssm_pkg::t_out_item  o_item
);

    logic                           r_busy;
    logic [ssm_pkg::CountWidth-1:0] r_cnt;
    ssm_pkg::t_pattern              r_shift;
    logic [3:0]                     r_enable_n;
    logic                           take;
    logic                           last;

    assign take    = r_busy && !i_stall;
    assign last    = (r_cnt == ssm_pkg::CountWidth'(ssm_pkg::BitsPerDigit - 1));
    assign o_ready = !r_busy || (take && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (take) begin
            if (last) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_shift    <= i_scan.pattern;
            r_enable_n <= i_scan.digit_enable_n;
        end else if (take) begin
            r_shift <= {r_shift[6:0], 1'b0};
        end
    end

    assign o_valid               = r_busy;
    assign o_item.digit_enable_n = r_enable_n;
    assign o_item.serial_bit     = r_shift[7];
    assign o_item.latch          = last;

endmodule
